/* src/ilc_pkg.sv */
package ilc_pkg;

  localparam int unsigned LevelW = 7;
  localparam int unsigned StepW  = 6;
  localparam int unsigned DelayW = 10;
  localparam int unsigned TimerBits = 10;

  // config port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = DelayW;

  typedef logic [LevelW-1:0]    level_t;
  typedef logic [StepW-1:0]     step_t;
  typedef logic [DelayW-1:0]    delay_t;
  typedef logic [TimerBits-1:0] timer_t;
  typedef logic [CfgIdxW-1:0]   cfg_idx_t;
  typedef logic [CfgDataW-1:0]  cfg_data_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinLevel  = 3'd0,
    CfgMaxLevel  = 3'd1,
    CfgLowLevel  = 3'd2,
    CfgStepSize  = 3'd3,
    CfgOffDelay  = 3'd4
  } cfg_reg_e;

  localparam level_t RstMinLevel  = level_t'(10);
  localparam level_t RstMaxLevel  = level_t'(100);
  localparam level_t RstLowLevel  = level_t'(20);
  localparam step_t  RstStepSize  = step_t'(5);
  localparam delay_t RstOffDelay  = delay_t'(250);
  localparam level_t RstRampLevel = level_t'(10);
  localparam level_t RstHeldLevel = level_t'(100);

  localparam timer_t TimerMax = '1;
  localparam int unsigned LoadW = (TimerBits > DelayW) ? TimerBits : DelayW;

  function automatic level_t at_least_min(level_t v, level_t min_lvl);
    return (v < min_lvl) ? min_lvl : v;
  endfunction

  // timer reload, saturated to the counter width
  function automatic timer_t delay_load(delay_t d);
    logic [LoadW-1:0] dw;
    dw = LoadW'(d);
    if (dw > LoadW'(TimerMax)) begin
      return TimerMax;
    end
    return TimerBits'(dw);
  endfunction

endpackage

/* src/indicator_led_controller_core.sv */
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | to core   | in_valid_i / in_stall_o   | caps_lock, touched, kbd_active, backlight
// out      | from core | out_valid_o / out_stall_i | led_level, led_written, held_level
// cfg      | to core   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One tick request per cycle sustained while out_stall_i is low. A request is held
// in the input register, the tick rules run combinationally from it and the state
// registers, and the result lands in the output register, which drives out_valid_o.
// Reset returns all state and config registers to their power-up values.
// out_stall_i holds the output register; the input register then fills and
// in_stall_o rises only once both stages are occupied.
module indicator_led_controller_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config
  input  logic                cfg_we_i,
  input  ilc_pkg::cfg_idx_t   cfg_idx_i,
  input  ilc_pkg::cfg_data_t  cfg_wdata_i,
  // tick requests
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                caps_lock_i,
  input  logic                touched_i,
  input  logic                kbd_active_i,
  input  ilc_pkg::level_t     backlight_level_i,
  // results
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ilc_pkg::level_t     led_level_o,
  output logic                led_written_o,
  output ilc_pkg::level_t     held_level_o
);
  import ilc_pkg::*;

  // ---------------------------------------------------------------- config
  level_t min_level_q, max_level_q, low_level_q;
  step_t  step_size_q;
  delay_t off_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q <= RstMinLevel;
      max_level_q <= RstMaxLevel;
      low_level_q <= RstLowLevel;
      step_size_q <= RstStepSize;
      off_delay_q <= RstOffDelay;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinLevel: min_level_q <= level_t'(cfg_wdata_i[LevelW-1:0]);
        CfgMaxLevel: max_level_q <= level_t'(cfg_wdata_i[LevelW-1:0]);
        CfgLowLevel: low_level_q <= level_t'(cfg_wdata_i[LevelW-1:0]);
        CfgStepSize: step_size_q <= step_t'(cfg_wdata_i[StepW-1:0]);
        CfgOffDelay: off_delay_q <= delay_t'(cfg_wdata_i[DelayW-1:0]);
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------- input stage
  logic   s1_valid_q;
  logic   s1_caps_q, s1_touch_q, s1_act_q;
  level_t s1_bl_q;
  logic   s1_adv;    // s1 request moves into the output register
  logic   in_acc;

  assign s1_adv     = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_caps_q  <= caps_lock_i;
      s1_touch_q <= touched_i;
      s1_act_q   <= kbd_active_i;
      s1_bl_q    <= backlight_level_i;
    end
  end

  // ----------------------------------------------------------- tick state
  logic   caps_seen_q, touch_seen_q, active_seen_q, ramp_rising_q, off_armed_q;
  level_t ramp_level_q, held_q, last_bl_q, shown_q;
  timer_t off_cnt_q;

  logic   caps_seen_d, touch_seen_d, active_seen_d, ramp_rising_d, off_armed_d;
  level_t ramp_level_d, held_d, last_bl_d, shown_d;
  timer_t off_cnt_d;
  logic   written, restarted;
  logic [LevelW:0] ramp_up, low_plus;

  always_comb begin
    caps_seen_d   = caps_seen_q;
    touch_seen_d  = touch_seen_q;
    active_seen_d = active_seen_q;
    ramp_rising_d = ramp_rising_q;
    off_armed_d   = off_armed_q;
    ramp_level_d  = ramp_level_q;
    held_d        = held_q;
    last_bl_d     = last_bl_q;
    shown_d       = shown_q;
    off_cnt_d     = off_cnt_q;
    written       = 1'b0;
    restarted     = 1'b0;
    ramp_up       = '0;
    low_plus      = '0;

    // poll rules
    if (s1_act_q != active_seen_q) begin
      active_seen_d = s1_act_q;
      if (s1_act_q) begin
        last_bl_d = s1_bl_q;
      end
    end

    if (s1_caps_q != caps_seen_q) begin
      caps_seen_d = s1_caps_q;
      if (s1_caps_q) begin
        ramp_level_d  = min_level_q;
        ramp_rising_d = 1'b1;
      end else if (s1_touch_q) begin
        touch_seen_d = 1'b1;
        if (active_seen_d) begin
          held_d = at_least_min(s1_bl_q, min_level_q);
        end
        shown_d     = held_d;
        written     = 1'b1;
        off_armed_d = 1'b0;
      end else begin
        shown_d = '0;
        written = 1'b1;
      end
    end

    if (!caps_seen_d && (s1_touch_q != touch_seen_d)) begin
      touch_seen_d = s1_touch_q;
      if (s1_touch_q) begin
        if (active_seen_d) begin
          held_d = at_least_min(s1_bl_q, min_level_q);
        end
        shown_d     = held_d;
        written     = 1'b1;
        off_armed_d = 1'b0;
      end else begin
        off_cnt_d   = delay_load(off_delay_q);
        off_armed_d = 1'b1;
        restarted   = 1'b1;
      end
    end

    if (!caps_seen_d && !touch_seen_d && (s1_bl_q != last_bl_d) && active_seen_d) begin
      last_bl_d = s1_bl_q;
      if (s1_bl_q != '0) begin
        held_d      = at_least_min(s1_bl_q, min_level_q);
        shown_d     = held_d;
        written     = 1'b1;
        off_cnt_d   = delay_load(off_delay_q);
        off_armed_d = 1'b1;
        restarted   = 1'b1;
      end
    end

    // breathing step, triangle between low and max
    if (caps_seen_d) begin
      ramp_up  = {1'b0, ramp_level_d} + (LevelW+1)'(step_size_q);
      low_plus = {1'b0, low_level_q} + (LevelW+1)'(step_size_q);
      if (ramp_rising_d) begin
        if (ramp_up >= {1'b0, max_level_q}) begin
          ramp_level_d  = max_level_q;
          ramp_rising_d = 1'b0;
        end else begin
          ramp_level_d = ramp_up[LevelW-1:0];
        end
      end else begin
        if ({1'b0, ramp_level_d} <= low_plus) begin
          ramp_level_d  = low_level_q;
          ramp_rising_d = 1'b1;
        end else begin
          ramp_level_d = ramp_level_d - level_t'(step_size_q);
        end
      end
      shown_d = ramp_level_d;
      written = 1'b1;
    end

    // auto-off countdown; a zero reload expires like one
    if (off_armed_d && !restarted) begin
      if (off_cnt_d <= timer_t'(1)) begin
        off_cnt_d   = '0;
        off_armed_d = 1'b0;
        if (!caps_seen_d && !touch_seen_d) begin
          shown_d = '0;
          written = 1'b1;
        end
      end else begin
        off_cnt_d = off_cnt_d - timer_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_seen_q   <= 1'b0;
      touch_seen_q  <= 1'b0;
      active_seen_q <= 1'b0;
      ramp_rising_q <= 1'b1;
      off_armed_q   <= 1'b0;
      ramp_level_q  <= RstRampLevel;
      held_q        <= RstHeldLevel;
      last_bl_q     <= '0;
      shown_q       <= '0;
      off_cnt_q     <= '0;
    end else if (s1_adv) begin
      caps_seen_q   <= caps_seen_d;
      touch_seen_q  <= touch_seen_d;
      active_seen_q <= active_seen_d;
      ramp_rising_q <= ramp_rising_d;
      off_armed_q   <= off_armed_d;
      ramp_level_q  <= ramp_level_d;
      held_q        <= held_d;
      last_bl_q     <= last_bl_d;
      shown_q       <= shown_d;
      off_cnt_q     <= off_cnt_d;
    end
  end

  // --------------------------------------------------------- output stage
  logic   out_valid_q;
  level_t out_led_q, out_held_q;
  logic   out_written_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_led_q     <= shown_d;
      out_written_q <= written;
      out_held_q    <= held_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_level_o   = out_led_q;
  assign led_written_o = out_written_q;
  assign held_level_o  = out_held_q;

  // ----------------------------------------------------------- assertions
  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i)
  ) else $error("input stalled with a free stage");

  a_s1_drains: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_o) |=> out_valid_o
  ) else $error("request in input register not moved to output");

  a_caps_writes: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && caps_seen_d) |=> led_written_o
  ) else $error("breathing tick did not write the LED");

endmodule

/* verif/ilc_tick_checker.sv */
module ilc_tick_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  ilc_pkg::cfg_idx_t  cfg_idx_i,
  input  ilc_pkg::cfg_data_t cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               caps_lock_i,
  input  logic               touched_i,
  input  logic               kbd_active_i,
  input  ilc_pkg::level_t    backlight_level_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  ilc_pkg::level_t    led_level_i,
  input  logic               led_written_i,
  input  ilc_pkg::level_t    held_level_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ilc_pkg::*;

  typedef struct packed {
    level_t led;
    logic   wr;
    level_t held;
  } led_result_t;

  // register copies
  level_t cfg_min, cfg_max, cfg_low;
  step_t  cfg_step;
  delay_t cfg_delay;

  // controller state as the block should hold it
  logic   caps_prev, touch_prev, active_prev;
  level_t ramp_lvl;
  logic   ramp_up;
  level_t held_lvl, last_bl, led_lvl;
  timer_t countdown;
  logic   timer_armed;

  led_result_t led_results_q[$];

  function automatic level_t clamp_to_min(level_t v);
    return (v < cfg_min) ? cfg_min : v;
  endfunction

  function automatic timer_t reload_value();
    return (32'(cfg_delay) > 32'(TimerMax)) ? TimerMax : timer_t'(cfg_delay);
  endfunction

  // poll rules, then one breathing step, then the auto-off countdown
  function automatic led_result_t advance_tick(logic caps, logic touch, logic act, level_t bl);
    logic        wr;
    logic        reloaded;
    led_result_t r;
    wr = 1'b0;
    reloaded = 1'b0;

    if (act != active_prev) begin
      active_prev = act;
      if (act) begin
        last_bl = bl;
      end
    end

    if (caps != caps_prev) begin
      caps_prev = caps;
      if (caps) begin
        ramp_lvl = cfg_min;
        ramp_up = 1'b1;
      end else if (touch) begin
        touch_prev = 1'b1;
        if (active_prev) begin
          held_lvl = clamp_to_min(bl);
        end
        led_lvl = held_lvl;
        wr = 1'b1;
        timer_armed = 1'b0;
      end else begin
        led_lvl = '0;
        wr = 1'b1;
      end
    end

    if (!caps_prev && touch != touch_prev) begin
      touch_prev = touch;
      if (touch) begin
        if (active_prev) begin
          held_lvl = clamp_to_min(bl);
        end
        led_lvl = held_lvl;
        wr = 1'b1;
        timer_armed = 1'b0;
      end else begin
        countdown = reload_value();
        timer_armed = 1'b1;
        reloaded = 1'b1;
      end
    end

    if (!caps_prev && !touch_prev && bl != last_bl && active_prev) begin
      last_bl = bl;
      if (bl != '0) begin
        held_lvl = clamp_to_min(bl);
        led_lvl = held_lvl;
        wr = 1'b1;
        countdown = reload_value();
        timer_armed = 1'b1;
        reloaded = 1'b1;
      end
    end

    if (caps_prev) begin
      if (ramp_up) begin
        if (int'(ramp_lvl) + int'(cfg_step) >= int'(cfg_max)) begin
          ramp_lvl = cfg_max;
          ramp_up = 1'b0;
        end else begin
          ramp_lvl = ramp_lvl + level_t'(cfg_step);
        end
      end else begin
        if (int'(ramp_lvl) <= int'(cfg_low) + int'(cfg_step)) begin
          ramp_lvl = cfg_low;
          ramp_up = 1'b1;
        end else begin
          ramp_lvl = ramp_lvl - level_t'(cfg_step);
        end
      end
      led_lvl = ramp_lvl;
      wr = 1'b1;
    end

    // no count in the tick that reloaded the timer
    if (timer_armed && !reloaded) begin
      if (countdown <= timer_t'(1)) begin
        countdown = '0;
        timer_armed = 1'b0;
        if (!caps_prev && !touch_prev) begin
          led_lvl = '0;
          wr = 1'b1;
        end
      end else begin
        countdown = countdown - timer_t'(1);
      end
    end

    r.led = led_lvl;
    r.wr = wr;
    r.held = held_lvl;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    led_result_t want;
    if (!rst_ni) begin
      cfg_min = RstMinLevel;
      cfg_max = RstMaxLevel;
      cfg_low = RstLowLevel;
      cfg_step = RstStepSize;
      cfg_delay = RstOffDelay;
      caps_prev = 1'b0;
      touch_prev = 1'b0;
      active_prev = 1'b0;
      ramp_lvl = RstRampLevel;
      ramp_up = 1'b1;
      held_lvl = RstHeldLevel;
      last_bl = '0;
      led_lvl = '0;
      countdown = '0;
      timer_armed = 1'b0;
      led_results_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CfgMinLevel: cfg_min = level_t'(cfg_wdata_i);
          CfgMaxLevel: cfg_max = level_t'(cfg_wdata_i);
          CfgLowLevel: cfg_low = level_t'(cfg_wdata_i);
          CfgStepSize: cfg_step = step_t'(cfg_wdata_i);
          CfgOffDelay: cfg_delay = delay_t'(cfg_wdata_i);
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        if (led_results_q.size() == 0) begin
          $error("result accepted with no tick request outstanding");
          fail_count_o++;
        end else begin
          want = led_results_q.pop_front();
          checked_o++;
          if (led_level_i !== want.led) begin
            $error("led_level: expected %0d, got %0d", want.led, led_level_i);
            fail_count_o++;
          end
          if (led_written_i !== want.wr) begin
            $error("led_written: expected %0d, got %0d", want.wr, led_written_i);
            fail_count_o++;
          end
          if (held_level_i !== want.held) begin
            $error("held_level: expected %0d, got %0d", want.held, held_level_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        led_results_q.push_back(advance_tick(caps_lock_i, touched_i, kbd_active_i,
                                             backlight_level_i));
      end
      pending_o = led_results_q.size();
    end
  end

endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ilc_pkg::*;

  // cycles with no request moving in either direction before the run is abandoned;
  // the slowest legal stretch is a drain plus a register write
  localparam int unsigned QuietLimit = 4000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;

  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_idx = '0;
  cfg_data_t cfg_wdata = '0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  logic      caps = 1'b0;
  logic      touch = 1'b0;
  logic      act = 1'b0;
  level_t    bl = '0;

  logic      out_valid;
  logic      out_stall = 1'b0;
  level_t    led_level;
  logic      led_written;
  level_t    held_level;

  int unsigned fails, pending, checked;
  int unsigned ticks_sent = 0;
  int unsigned settings_applied = 0;
  int unsigned quiet = 0;

  // gaps on the request side and stalls on the result side; both are
  // switched off together for one long phase
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;

  // running input picture for the random part: each field changes on its own draw
  logic   cur_caps = 1'b0;
  logic   cur_touch = 1'b0;
  logic   cur_act = 1'b0;
  level_t cur_bl = '0;

  always #6 clk_i = ~clk_i;

  indicator_led_controller_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .caps_lock_i       (caps),
    .touched_i         (touch),
    .kbd_active_i      (act),
    .backlight_level_i (bl),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .led_level_o       (led_level),
    .led_written_o     (led_written),
    .held_level_o      (held_level)
  );

  ilc_tick_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .caps_lock_i       (caps),
    .touched_i         (touch),
    .kbd_active_i      (act),
    .backlight_level_i (bl),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .led_level_i       (led_level),
    .led_written_i     (led_written),
    .held_level_i      (held_level),
    .fail_count_o      (fails),
    .pending_o         (pending),
    .checked_o         (checked)
  );

  // result side back-pressure, roughly a third of cycles while enabled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= stall_on && ($urandom_range(0, 99) < 33);
    end
  end

  // watchdog: any accepted request or result resets the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $error("no request or result moved for %0d cycles", QuietLimit);
        $display("tb: failure");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  // Presents one tick request and holds it until accepted. Valid is only
  // dropped when a gap is taken, so it never falls and rises in one step.
  task automatic send_tick(input logic c, input logic t, input logic a, input level_t b);
    if (gaps_on && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < 25) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    caps <= c;
    touch <= t;
    act <= a;
    bl <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    ticks_sent++;
  endtask

  // Waits until every outstanding result has been taken; sampled on the
  // falling edge so the checker's count is settled. Returns on a rising edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Writes all five registers back to back; only called with the block idle.
  task automatic apply_setting(input level_t mn, input level_t mx, input level_t lo,
                               input step_t st, input delay_t dl);
    cfg_we <= 1'b1;
    cfg_idx <= CfgMinLevel;
    cfg_wdata <= cfg_data_t'(mn);
    @(posedge clk_i);
    cfg_idx <= CfgMaxLevel;
    cfg_wdata <= cfg_data_t'(mx);
    @(posedge clk_i);
    cfg_idx <= CfgLowLevel;
    cfg_wdata <= cfg_data_t'(lo);
    @(posedge clk_i);
    cfg_idx <= CfgStepSize;
    cfg_wdata <= cfg_data_t'(st);
    @(posedge clk_i);
    cfg_idx <= CfgOffDelay;
    cfg_wdata <= cfg_data_t'(dl);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Backlight picks: some zeros, a few above the nominal 100 %, mostly in range.
  function automatic level_t pick_backlight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return level_t'($urandom_range(101, 127));
    return level_t'($urandom_range(1, 100));
  endfunction

  // Mostly plausible keyboard behaviour: caps lock held for long stretches so the
  // ramp turns at both ends, touches and backlight changes now and then so the
  // auto-off timer gets restarted, cancelled and left to expire. About one tick in
  // eight is noise with every field drawn fresh.
  task automatic run_random(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 12) begin
        cur_caps = 1'($urandom);
        cur_touch = 1'($urandom);
        cur_act = 1'($urandom);
        cur_bl = pick_backlight();
      end else begin
        if ($urandom_range(0, 99) < 4) cur_caps = !cur_caps;
        if ($urandom_range(0, 99) < 10) cur_touch = !cur_touch;
        if ($urandom_range(0, 99) < 6) cur_act = !cur_act;
        if ($urandom_range(0, 99) < 15) cur_bl = pick_backlight();
      end
      send_tick(cur_caps, cur_touch, cur_act, cur_bl);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks at the power-up register values.
    send_tick(1'b0, 1'b0, 1'b0, 7'd0);    // nothing happening
    send_tick(1'b0, 1'b0, 1'b1, 7'd50);   // activity starts, backlight noted, no write
    send_tick(1'b0, 1'b0, 1'b1, 7'd100);  // backlight change shows it, timer restarts
    send_tick(1'b0, 1'b0, 1'b1, 7'd0);    // change to zero: only noted
    send_tick(1'b0, 1'b0, 1'b1, 7'd3);    // below the floor, shown at min
    send_tick(1'b0, 1'b1, 1'b1, 7'd127);  // touch takes the backlight, timer cancelled
    send_tick(1'b0, 1'b0, 1'b1, 7'd127);  // release restarts the timer
    send_tick(1'b1, 1'b0, 1'b1, 7'd127);  // caps on: ramp from min, first step at once
    send_tick(1'b1, 1'b1, 1'b1, 7'd64);   // touch under caps lock is ignored
    send_tick(1'b1, 1'b0, 1'b0, 7'd1);
    send_tick(1'b1, 1'b0, 1'b0, 7'd1);
    send_tick(1'b0, 1'b1, 1'b1, 7'd77);   // caps off while touched: held level shown
    send_tick(1'b0, 1'b0, 1'b1, 7'd77);
    send_tick(1'b1, 1'b0, 1'b1, 7'd77);
    send_tick(1'b0, 1'b0, 1'b1, 7'd77);   // caps off untouched: LED blanked
    send_tick(1'b0, 1'b0, 1'b0, 7'd90);   // activity ends, backlight ignored
    send_tick(1'b0, 1'b1, 1'b0, 7'd42);   // touch while idle keeps the held level
    send_tick(1'b0, 1'b0, 1'b0, 7'd42);
    send_tick(1'b0, 1'b0, 1'b1, 7'd42);
    send_tick(1'b0, 1'b0, 1'b1, 7'd127);
    drain();

    // Lowest legal settings: ramp between 0 and 1, timer expires next tick.
    apply_setting(7'd0, 7'd1, 7'd0, 6'd1, 10'd1);
    run_random(50);
    drain();

    // Highest legal settings: ramp turns every tick, longest timer.
    apply_setting(7'd100, 7'd100, 7'd100, 6'd50, 10'd1023);
    run_random(40);
    drain();

    // Back-to-back requests with the result side never stalling.
    gaps_on = 1'b0;
    stall_on = 1'b0;
    apply_setting(7'd10, 7'd100, 7'd20, 6'd5, 10'd2);
    run_random(60);
    drain();
    gaps_on = 1'b1;
    stall_on = 1'b1;

    // Random legal settings with short timers so expiry is common.
    repeat (4) begin
      apply_setting(level_t'($urandom_range(0, 100)), level_t'($urandom_range(1, 100)),
                    level_t'($urandom_range(0, 100)), step_t'($urandom_range(1, 50)),
                    delay_t'($urandom_range(1, 24)));
      run_random(60);
      drain();
    end

    // Out-of-range values: zero step holds the ramp, zero delay behaves as one,
    // and levels beyond 100 are used as written.
    apply_setting(7'd120, 7'd127, 7'd0, 6'd0, 10'd0);
    run_random(30);
    drain();
    apply_setting(7'd0, 7'd127, 7'd127, 6'd63, 10'd3);
    run_random(30);
    drain();

    // allow for anything still in the two pipeline stages
    repeat (4) @(posedge clk_i);

    $display("Summary: %0d tick requests under %0d register settings plus power-up values,",
             ticks_sent, settings_applied);
    $display("         %0d results compared field by field", checked);
    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
